// ----- src/sws_pkg.sv -----
// shared types and constants for the stack with search and sort
// used by stack_with_search_and_sort_top; no dependencies
package sws_pkg;

  // default sizes for the top-level parameters
  localparam int unsigned DepthDefault     = 64;
  localparam int unsigned DataWidthDefault = 32;

  // fixed field widths of the stream payloads
  localparam int unsigned OpWidth      = 3;
  localparam int unsigned OutDataWidth = 32;
  localparam int unsigned IndexWidth   = 6;
  localparam int unsigned StatusWidth  = 2;

  // command codes
  typedef enum logic [OpWidth-1:0] {
    OP_PUSH        = 3'd0,
    OP_POP         = 3'd1,
    OP_READ_TOP    = 3'd2,
    OP_READ_BOTTOM = 3'd3,
    OP_SEARCH      = 3'd4,
    OP_SORT        = 3'd5
  } op_e;

  // result status codes
  typedef enum logic [StatusWidth-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  // one result, data in the lowest bits
  typedef struct packed {
    status_e                 status;
    logic                    full_res;
    logic                    empty_res;
    logic [IndexWidth-1:0]   index;
    logic                    found;
    logic [OutDataWidth-1:0] data;
  } res_t;

endpackage

// ----- src/sws_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module sws_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrWidth = $clog2(Depth)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrWidth-1:0] waddr_i,
  input  logic [Width-1:0]     wdata_i,
  input  logic                 re_i,
  input  logic [AddrWidth-1:0] raddr_i,
  output logic [Width-1:0]     rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/stack_with_search_and_sort_top.sv -----
// bounded lifo stack of signed words with search and in-place sort
// depends on sws_pkg and sws_ram
//
//   channel  dir  payload                                          handshake
//   s_axis   in   tdata: op[2:0], value[DATA_WIDTH-1:0]            tvalid/tready
//   m_axis   out  tdata: data, found, index, empty_res,            tvalid/tready
//                        full_res, status
//
// push, pop, unused codes, a one-entry sort and rejected commands finish in the accept cycle.
// read top / read bottom make one ram read; search makes one ram read per cycle, scanning
// entries from the top until a match or the bottom.
// sort is a selection sort on the ram: each pass scans the unsorted entries for the
// minimum and swaps it into place; the single read port paces the scan.
// reset clears the entry count, the state and the result valid flag; the ram is left as is.
// a request is taken when idle and the result register is empty or being drained.
module stack_with_search_and_sort_top #(
  parameter int unsigned DEPTH      = sws_pkg::DepthDefault,
  parameter int unsigned DATA_WIDTH = sws_pkg::DataWidthDefault,
  localparam int unsigned InTdataWidth  = ((sws_pkg::OpWidth + DATA_WIDTH + 7) / 8) * 8,
  localparam int unsigned ResWidth      = $bits(sws_pkg::res_t),
  localparam int unsigned OutTdataWidth = ((ResWidth + 7) / 8) * 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // op, value
  input  logic [InTdataWidth-1:0]  s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // data, found, index, empty_res, full_res, status
  output logic [OutTdataWidth-1:0] m_axis_tdata
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SEARCH,
    ST_SORT_START,
    ST_SORT_SCAN,
    ST_SORT_WR_LO,
    ST_SORT_WR_HI
  } state_e;

  state_e              state_q;
  logic [CW-1:0]       count_q;
  logic [AW-1:0]       iss_idx_q;
  logic                iss_more_q;
  logic [AW-1:0]       cmp_idx_q;
  logic [AW-1:0]       pass_q;
  logic                first_q;
  logic [DATA_WIDTH-1:0] val_q;
  logic [DATA_WIDTH-1:0] min_val_q;
  logic [AW-1:0]       min_idx_q;
  logic [DATA_WIDTH-1:0] first_val_q;
  logic                out_vld_q;
  sws_pkg::res_t       out_q;

  // ram ports
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  // decoded request and helpers
  logic                  accept;
  sws_pkg::op_e          op_in;
  logic [DATA_WIDTH-1:0] val_in;
  logic                  is_empty;
  logic                  is_full;
  logic [CW-1:0]         cnt_m1;
  logic [AW-1:0]         top_idx;
  logic [AW-1:0]         pass_nxt;
  logic                  rd_match;
  logic                  rd_less;
  logic [DATA_WIDTH+sws_pkg::OutDataWidth-1:0] rd_wide;
  logic [AW+sws_pkg::IndexWidth-1:0]           idx_wide;
  logic [sws_pkg::OutDataWidth-1:0]            rd_out;
  logic [sws_pkg::IndexWidth-1:0]              idx_out;

  assign s_axis_tready = (state_q == ST_IDLE) && (!out_vld_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign op_in         = sws_pkg::op_e'(s_axis_tdata[sws_pkg::OpWidth-1:0]);
  assign val_in        = s_axis_tdata[sws_pkg::OpWidth +: DATA_WIDTH];
  assign is_empty      = (count_q == '0);
  assign is_full       = (count_q == CW'(DEPTH));
  assign cnt_m1        = count_q - CW'(1);
  assign top_idx       = cnt_m1[AW-1:0];
  assign pass_nxt      = pass_q + AW'(1);
  assign rd_match      = (ram_rdata == val_q);
  assign rd_less       = $signed(ram_rdata) < $signed(min_val_q);

  // zero-extend or truncate to the fixed result field widths
  assign rd_wide  = {{sws_pkg::OutDataWidth{1'b0}}, ram_rdata};
  assign rd_out   = rd_wide[sws_pkg::OutDataWidth-1:0];
  assign idx_wide = {{sws_pkg::IndexWidth{1'b0}}, cmp_idx_q};
  assign idx_out  = idx_wide[sws_pkg::IndexWidth-1:0];

  // ram access per state
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count_q[AW-1:0];
    ram_wdata = val_in;
    ram_re    = 1'b0;
    ram_raddr = top_idx;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (op_in)
            sws_pkg::OP_PUSH: begin
              ram_we = !is_full;
            end
            sws_pkg::OP_READ_TOP,
            sws_pkg::OP_SEARCH: begin
              ram_re = !is_empty;
            end
            sws_pkg::OP_READ_BOTTOM: begin
              ram_re    = !is_empty;
              ram_raddr = '0;
            end
            default: begin
              ram_re = 1'b0;
            end
          endcase
        end
      end
      ST_SEARCH,
      ST_SORT_SCAN: begin
        ram_re    = iss_more_q;
        ram_raddr = iss_idx_q;
      end
      ST_SORT_START: begin
        ram_re    = 1'b1;
        ram_raddr = pass_q;
      end
      ST_SORT_WR_LO: begin
        ram_we    = 1'b1;
        ram_waddr = pass_q;
        ram_wdata = min_val_q;
      end
      ST_SORT_WR_HI: begin
        ram_we    = 1'b1;
        ram_waddr = min_idx_q;
        ram_wdata = first_val_q;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  sws_ram #(
    .Width (DATA_WIDTH),
    .Depth (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // sequencer, count and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      iss_more_q <= 1'b0;
      first_q    <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      // result drained
      if (out_vld_q && m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            val_q           <= val_in;
            out_q.data      <= '0;
            out_q.found     <= 1'b0;
            out_q.index     <= '0;
            out_q.status    <= sws_pkg::STATUS_OK;
            out_q.empty_res <= is_empty;
            out_q.full_res  <= is_full;
            case (op_in)
              sws_pkg::OP_PUSH: begin
                out_vld_q <= 1'b1;
                if (is_full) begin
                  out_q.status <= sws_pkg::STATUS_FULL;
                end else begin
                  count_q         <= count_q + CW'(1);
                  out_q.empty_res <= 1'b0;
                  out_q.full_res  <= (count_q + CW'(1)) == CW'(DEPTH);
                end
              end
              sws_pkg::OP_POP: begin
                out_vld_q <= 1'b1;
                if (is_empty) begin
                  out_q.status <= sws_pkg::STATUS_EMPTY;
                end else begin
                  count_q         <= cnt_m1;
                  out_q.empty_res <= (cnt_m1 == '0);
                  out_q.full_res  <= 1'b0;
                end
              end
              sws_pkg::OP_READ_TOP,
              sws_pkg::OP_READ_BOTTOM: begin
                if (is_empty) begin
                  out_vld_q    <= 1'b1;
                  out_q.status <= sws_pkg::STATUS_EMPTY;
                end else begin
                  state_q <= ST_READ;
                end
              end
              sws_pkg::OP_SEARCH: begin
                if (is_empty) begin
                  out_vld_q    <= 1'b1;
                  out_q.status <= sws_pkg::STATUS_EMPTY;
                end else begin
                  cmp_idx_q  <= top_idx;
                  iss_idx_q  <= top_idx - AW'(1);
                  iss_more_q <= (top_idx != '0);
                  state_q    <= ST_SEARCH;
                end
              end
              sws_pkg::OP_SORT: begin
                if (is_empty) begin
                  out_vld_q    <= 1'b1;
                  out_q.status <= sws_pkg::STATUS_EMPTY;
                end else if (top_idx == '0) begin
                  // a single entry is already in order
                  out_vld_q <= 1'b1;
                end else begin
                  pass_q  <= '0;
                  state_q <= ST_SORT_START;
                end
              end
              default: begin
                out_vld_q <= 1'b1;
              end
            endcase
          end
        end
        ST_READ: begin
          out_q.data <= rd_out;
          out_vld_q  <= 1'b1;
          state_q    <= ST_IDLE;
        end
        ST_SEARCH: begin
          if (rd_match) begin
            out_q.found <= 1'b1;
            out_q.index <= idx_out;
            out_vld_q   <= 1'b1;
            iss_more_q  <= 1'b0;
            state_q     <= ST_IDLE;
          end else if (iss_more_q) begin
            cmp_idx_q  <= iss_idx_q;
            iss_idx_q  <= iss_idx_q - AW'(1);
            iss_more_q <= (iss_idx_q != '0);
          end else begin
            out_vld_q <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end
        ST_SORT_START: begin
          cmp_idx_q  <= pass_q;
          iss_idx_q  <= pass_nxt;
          iss_more_q <= 1'b1;
          first_q    <= 1'b1;
          state_q    <= ST_SORT_SCAN;
        end
        ST_SORT_SCAN: begin
          // track the minimum of this pass
          if (first_q) begin
            min_val_q   <= ram_rdata;
            min_idx_q   <= cmp_idx_q;
            first_val_q <= ram_rdata;
            first_q     <= 1'b0;
          end else if (rd_less) begin
            min_val_q <= ram_rdata;
            min_idx_q <= cmp_idx_q;
          end
          if (iss_more_q) begin
            cmp_idx_q  <= iss_idx_q;
            iss_idx_q  <= iss_idx_q + AW'(1);
            iss_more_q <= (iss_idx_q != top_idx);
          end else begin
            state_q <= ST_SORT_WR_LO;
          end
        end
        ST_SORT_WR_LO: begin
          state_q <= ST_SORT_WR_HI;
        end
        ST_SORT_WR_HI: begin
          pass_q <= pass_nxt;
          if (pass_nxt == top_idx) begin
            out_vld_q <= 1'b1;
            state_q   <= ST_IDLE;
          end else begin
            state_q <= ST_SORT_START;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OutTdataWidth'(out_q);

`ifndef SYNTHESIS
  // entry count stays within the stack depth
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CW'(DEPTH))
    else $error("entry count beyond depth");

  // a multi-cycle command never runs while a result is still held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !out_vld_q)
    else $error("result register busy during a command");

  // the ram is never read and written at the same entry in one cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re && (ram_waddr == ram_raddr)))
    else $error("ram read and write collide");

  // the count moves only when a request is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(count_q))
    else $error("count changed without a request");
`endif

endmodule

// ----- dv/sws_checker.sv -----
`timescale 1ns / 1ps
// checker for the stack with search and sort: watches both stream channels,
// predicts every result from its own copy of the stack and compares it
// depends on sws_pkg
module sws_checker #(
  parameter int unsigned DEPTH         = sws_pkg::DepthDefault,
  parameter int unsigned DATA_WIDTH    = sws_pkg::DataWidthDefault,
  parameter int unsigned InTdataWidth  = 40,
  parameter int unsigned OutTdataWidth = 48
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid_i,
  input  logic                     s_axis_tready_i,
  // op, value
  input  logic [InTdataWidth-1:0]  s_axis_tdata_i,
  input  logic                     m_axis_tvalid_i,
  input  logic                     m_axis_tready_i,
  // data, found, index, empty_res, full_res, status
  input  logic [OutTdataWidth-1:0] m_axis_tdata_i,
  output int                       fail_count_o,
  output int                       pending_o
);
  import sws_pkg::*;

  localparam int unsigned ResWidth = $bits(res_t);

  // shadow copy of the stack
  logic signed [DATA_WIDTH-1:0] shadow_mem [DEPTH];
  int unsigned                  shadow_count;

  // results still owed by the block, oldest first
  res_t                         owed_results [$];

  // apply one request to the shadow stack and queue the result it causes
  task automatic apply_request(input logic [OpWidth-1:0] op,
                               input logic signed [DATA_WIDTH-1:0] value);
    res_t                         res;
    int                           i;
    int                           j;
    logic signed [DATA_WIDTH-1:0] tmp;
    res = '0;
    res.status = STATUS_OK;
    case (op)
      OP_PUSH: begin
        if (shadow_count >= DEPTH) begin
          res.status = STATUS_FULL;
        end else begin
          shadow_mem[shadow_count] = value;
          shadow_count++;
        end
      end
      OP_POP, OP_READ_TOP, OP_READ_BOTTOM, OP_SEARCH, OP_SORT: begin
        if (shadow_count == 0) begin
          res.status = STATUS_EMPTY;
        end else begin
          case (op)
            OP_POP:         shadow_count--;
            OP_READ_TOP:    res.data = OutDataWidth'($unsigned(shadow_mem[shadow_count-1]));
            OP_READ_BOTTOM: res.data = OutDataWidth'($unsigned(shadow_mem[0]));
            OP_SEARCH: begin
              // top down, first match wins
              for (i = int'(shadow_count) - 1; i >= 0 && !res.found; i--) begin
                if (shadow_mem[i] == value) begin
                  res.found = 1'b1;
                  res.index = IndexWidth'(i);
                end
              end
            end
            default: begin
              // ascending signed order, smallest at the bottom
              for (i = 0; i + 1 < int'(shadow_count); i++) begin
                for (j = i + 1; j < int'(shadow_count); j++) begin
                  if (shadow_mem[i] > shadow_mem[j]) begin
                    tmp           = shadow_mem[i];
                    shadow_mem[i] = shadow_mem[j];
                    shadow_mem[j] = tmp;
                  end
                end
              end
            end
          endcase
        end
      end
      default: ;
    endcase
    res.empty_res = (shadow_count == 0);
    res.full_res  = (shadow_count >= DEPTH);
    owed_results.push_back(res);
  endtask

  // one field of one result
  task automatic check_field(input string name, input longint exp_val,
                             input longint act_val);
    if (exp_val != act_val) begin
      $display("%0t: result field %s expected %0h actual %0h", $time, name,
               exp_val, act_val);
      fail_count_o++;
    end
  endtask

  // results first: a result never belongs to a request taken at the same edge
  always @(posedge clk_i or negedge rst_ni) begin : watch
    res_t exp_res;
    res_t act_res;
    if (!rst_ni) begin
      owed_results.delete();
      shadow_count = 0;
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        act_res = res_t'(m_axis_tdata_i[ResWidth-1:0]);
        if (owed_results.size() == 0) begin
          $display("%0t: unexpected result expected none actual %0h", $time, act_res);
          fail_count_o++;
        end else begin
          exp_res = owed_results.pop_front();
          check_field("data", exp_res.data, act_res.data);
          check_field("found", exp_res.found, act_res.found);
          check_field("index", exp_res.index, act_res.index);
          check_field("empty_res", exp_res.empty_res, act_res.empty_res);
          check_field("full_res", exp_res.full_res, act_res.full_res);
          check_field("status", exp_res.status, act_res.status);
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        apply_request(s_axis_tdata_i[OpWidth-1:0],
                      s_axis_tdata_i[OpWidth +: DATA_WIDTH]);
      end
      pending_o = owed_results.size();
    end
  end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// testbench top for the stack with search and sort: clock, reset, stimulus
// and verdict; depends on sws_pkg, sws_checker and the block itself
module tb_top;
  import sws_pkg::*;

  localparam int unsigned Depth         = DepthDefault;
  localparam int unsigned DataWidth     = DataWidthDefault;
  localparam int unsigned InTdataWidth  = ((OpWidth + DataWidth + 7) / 8) * 8;
  localparam int unsigned OutTdataWidth = (($bits(res_t) + 7) / 8) * 8;

  // op codes the block treats as no operation
  localparam logic [OpWidth-1:0] OpUnusedLo = 3'd6;
  localparam logic [OpWidth-1:0] OpUnusedHi = 3'd7;

  localparam int RandomItems   = 1050;
  localparam int TailItems     = 150;
  localparam int HoldOffItem   = 300;
  localparam int HoldOffCycles = 300;
  localparam int DrainCycles   = 50;
  localparam int CycleLimit    = 12_000_000;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} mix_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [InTdataWidth-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OutTdataWidth-1:0] m_tdata;
  int fail_count;
  int pending;

  // shared between sender and receiver
  bit idle_on = 1'b0;
  bit quiet_tail = 1'b0;
  bit hold_off_req = 1'b0;

  // recently pushed words, reused as search keys and duplicates
  logic [DataWidth-1:0] recent_vals [16] = '{default: '0};
  int unsigned recent_ptr = 0;

  stack_with_search_and_sort_top #(
    .DEPTH(Depth),
    .DATA_WIDTH(DataWidth)
  ) DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .s_axis_tdata(s_tdata),
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata(m_tdata)
  );

  sws_checker #(
    .DEPTH(Depth),
    .DATA_WIDTH(DataWidth),
    .InTdataWidth(InTdataWidth),
    .OutTdataWidth(OutTdataWidth)
  ) u_checker (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_i(s_tready),
    .s_axis_tdata_i(s_tdata),
    .m_axis_tvalid_i(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_i(m_tdata),
    .fail_count_o(fail_count),
    .pending_o(pending)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // receiver: random stall bursts, one long hold-off to back up the input
  initial begin : sink
    bit hold_off_done;
    hold_off_done = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req && !hold_off_done) begin
        hold_off_done = 1'b1;
        m_tready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
        m_tready <= 1'b1;
      end else if (idle_on && !quiet_tail && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // offer one request, optionally after a gap, and wait until it is taken
  task automatic send_request(input logic [OpWidth-1:0] op,
                              input logic [DataWidth-1:0] value);
    if (idle_on && !quiet_tail && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= InTdataWidth'({value, op});
    if (op == OP_PUSH) begin
      recent_vals[recent_ptr % 16] = value;
      recent_ptr++;
    end
    do @(posedge clk_i); while (!s_tready);
  endtask

  // word mix: full range, small values with many repeats, extremes, recent pushes
  function automatic logic [DataWidth-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return DataWidth'($urandom);
      4, 5, 6:    return DataWidth'($signed($urandom_range(0, 6)) - 3);
      7:          return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default:    return recent_vals[$urandom_range(0, 15)];
    endcase
  endfunction

  // command mix per phase
  function automatic logic [OpWidth-1:0] pick_op(input mix_mode_e mode);
    int roll;
    roll = $urandom_range(0, 99);
    case (mode)
      MODE_FILL: begin
        if (roll < 85) return OP_PUSH;
        if (roll < 90) return OP_POP;
        if (roll < 93) return OP_READ_TOP;
        if (roll < 95) return OP_READ_BOTTOM;
        if (roll < 98) return OP_SEARCH;
        if (roll < 99) return OP_SORT;
      end
      MODE_DRAIN: begin
        if (roll < 20) return OP_PUSH;
        if (roll < 70) return OP_POP;
        if (roll < 78) return OP_READ_TOP;
        if (roll < 84) return OP_READ_BOTTOM;
        if (roll < 94) return OP_SEARCH;
        if (roll < 97) return OP_SORT;
      end
      default: begin
        if (roll < 40) return OP_PUSH;
        if (roll < 62) return OP_POP;
        if (roll < 70) return OP_READ_TOP;
        if (roll < 78) return OP_READ_BOTTOM;
        if (roll < 92) return OP_SEARCH;
        if (roll < 96) return OP_SORT;
      end
    endcase
    return $urandom_range(0, 1) ? OpUnusedHi : OpUnusedLo;
  endfunction

  // stimulus and verdict
  initial begin : stimulus
    int        sent;
    int        k;
    int        seg_len;
    mix_mode_e mode;
    sent = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty stack: every command but push is rejected, unused codes do nothing
    send_request(OP_POP, 32'd1);
    send_request(OP_READ_TOP, 32'd0);
    send_request(OP_READ_BOTTOM, 32'd0);
    send_request(OP_SEARCH, 32'd0);
    send_request(OP_SORT, 32'd0);
    send_request(OpUnusedLo, 32'hffff_ffff);
    send_request(OpUnusedHi, 32'd0);
    // extremes of the word
    send_request(OP_PUSH, 32'h7fff_ffff);
    send_request(OP_PUSH, 32'h8000_0000);
    send_request(OP_PUSH, 32'd0);
    send_request(OP_PUSH, 32'hffff_ffff);
    send_request(OP_PUSH, 32'd5);
    send_request(OP_READ_TOP, 32'd0);
    send_request(OP_READ_BOTTOM, 32'd0);
    // search hit, miss, and a duplicate where the upper copy must win
    send_request(OP_SEARCH, 32'h8000_0000);
    send_request(OP_SEARCH, 32'd12345);
    send_request(OP_PUSH, 32'hffff_ffff);
    send_request(OP_SEARCH, 32'hffff_ffff);
    send_request(OP_SORT, 32'd0);
    send_request(OP_READ_BOTTOM, 32'd0);
    send_request(OP_READ_TOP, 32'd0);
    send_request(OpUnusedLo, 32'd0);
    send_request(OP_POP, 32'd0);
    send_request(OP_POP, 32'd0);

    // random phases; the first one fills the stack to reach the full cases
    while (sent < RandomItems) begin
      mode    = (sent == 0) ? MODE_FILL : mix_mode_e'($urandom_range(0, 2));
      seg_len = $urandom_range(60, 160);
      idle_on = ($urandom_range(0, 3) != 0);
      for (k = 0; k < seg_len && sent < RandomItems; k++) begin
        quiet_tail = (sent >= RandomItems - TailItems);
        if (sent == HoldOffItem) hold_off_req = 1'b1;
        send_request(pick_op(mode), pick_value());
        sent++;
      end
    end
    s_tvalid <= 1'b0;

    // let every owed result come back, then watch for strays
    // the last request is counted as owed before the pending check starts
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/sws_pkg.sv
src/sws_ram.sv
src/stack_with_search_and_sort_top.sv
dv/sws_checker.sv
dv/tb_top.sv
